>>> design/ycc_pkg.sv
// Shared types and constants for the YCbCr/RGB color converter.
// Holds Q16 coefficient tables, offsets, register indexes and the stage control word.
package ycc_pkg;

	localparam int COMP_W  = 8;
	localparam int X_W     = 9;
	localparam int COEF_W  = 18;
	localparam int PROD_W  = X_W + COEF_W;
	localparam int ACC_W   = PROD_W + 1;
	localparam int FRAC_W  = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LUMA_OFS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SWAP_GB   = 2'd2;

	localparam logic DIR_YCC_TO_RGB = 1'b0;
	localparam logic DIR_RGB_TO_YCC = 1'b1;

	typedef logic signed [X_W-1:0]    x_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic swap;
	} ctl_t;

	// [direction][output channel][input component], signed Q16 values carrying the sign of the term
	localparam coef_t COEF [2][3][3] = '{
		'{
			'{18'sd65536,  18'sd0,      18'sd91881},
			'{18'sd65536, -18'sd22554, -18'sd46820},
			'{18'sd65536,  18'sd116130, 18'sd0}
		},
		'{
			'{ 18'sd19595,  18'sd38470,  18'sd7471},
			'{-18'sd11056, -18'sd21712,  18'sd32768},
			'{ 18'sd32768, -18'sd27440, -18'sd5328}
		}
	};

	// chroma midpoint 128 in Q16 for the Cb and Cr outputs
	localparam acc_t BASE [2][3] = '{
		'{28'sd0, 28'sd0,       28'sd0},
		'{28'sd0, 28'sd8388608, 28'sd8388608}
	};

endpackage

>>> design/ycc_mac.sv
// Product and sum stages of the converter: nine signed products, then three sums.
// Depends on ycc_pkg for coefficient tables and the control word.
module ycc_mac
	import ycc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  ctl_t ctl_s1,
	input  logic dir_s1,
	input  x_t   x_s1 [3],
	output ctl_t ctl_s3,
	output acc_t acc_s3 [3]
);

	ctl_t  ctl_s2;
	logic  dir_s2;
	prod_t prod_s2 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		dir_s2 <= dir_s1;
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				prod_s2[k][j] <= prod_t'(COEF[dir_s1][k][j]) * prod_t'(x_s1[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			acc_s3[k] <= BASE[dir_s2][k] + ACC_W'(prod_s2[k][0])
				+ ACC_W'(prod_s2[k][1]) + ACC_W'(prod_s2[k][2]);
		end
	end

endmodule

>>> design/ycc_sat.sv
// Output stage: floors Q16 sums, saturates to 0..255 and applies the green/blue swap.
// Depends on ycc_pkg for widths and the control word.
module ycc_sat
	import ycc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl_s3,
	input  acc_t              acc_s3 [3],
	output logic              done,
	output logic              last_pixel,
	output logic [COMP_W-1:0] out0,
	output logic [COMP_W-1:0] out1,
	output logic [COMP_W-1:0] out2
);

	logic [COMP_W-1:0] sat [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (acc_s3[k][ACC_W-1]) begin
				sat[k] = '0;
			end else if (|acc_s3[k][ACC_W-2:FRAC_W+COMP_W]) begin
				sat[k] = '1;
			end else begin
				sat[k] = acc_s3[k][FRAC_W+COMP_W-1:FRAC_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		last_pixel <= ctl_s3.last;
		out0       <= sat[0];
		out1       <= ctl_s3.swap ? sat[2] : sat[1];
		out2       <= ctl_s3.swap ? sat[1] : sat[2];
	end

endmodule

>>> design/ycbcr_rgb_color_convert.sv
// Top level of the YCbCr/RGB color converter: config registers and input stage.
// Depends on ycc_pkg, ycc_mac and ycc_sat.
//
//   channel   handshake        word
//   input     start / busy     comp0, comp1, comp2, frame_end
//   result    done             out0, out1, out2, last_pixel
//   config    cfg_wr_en        cfg_index, cfg_data
//
// One pixel enters per clock; busy stays low. Each pixel passes through the input stage,
// product stage, sum stage and saturation stage before its result leaves.
// arst_n clears the config registers and all stage valid bits.
// The receiver cannot stall, so the pipeline never holds.
module ycbcr_rgb_color_convert
	import ycc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [COMP_W-1:0]     comp0,
	input  logic [COMP_W-1:0]     comp1,
	input  logic [COMP_W-1:0]     comp2,
	input  logic                  frame_end,
	output logic                  done,
	output logic [COMP_W-1:0]     out0,
	output logic [COMP_W-1:0]     out1,
	output logic [COMP_W-1:0]     out2,
	output logic                  last_pixel,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic                   direction_q;
	logic signed [X_W-1:0]  luma_offset_q;
	logic                   swap_q;

	logic signed [X_W:0]    y_sum;
	logic [COMP_W-1:0]      y_clamp;
	x_t                     x_in [3];

	ctl_t ctl_s1;
	logic dir_s1;
	x_t   x_s1 [3];
	ctl_t ctl_s3;
	acc_t acc_s3 [3];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q   <= DIR_YCC_TO_RGB;
			luma_offset_q <= '0;
			swap_q        <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DIRECTION: direction_q   <= cfg_data[0];
				REG_LUMA_OFS:  luma_offset_q <= cfg_data;
				REG_SWAP_GB:   swap_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		y_sum = $signed({2'b00, comp0}) + (X_W+1)'(luma_offset_q);
		if (y_sum[X_W]) begin
			y_clamp = '0;
		end else if (y_sum[X_W-1]) begin
			y_clamp = '1;
		end else begin
			y_clamp = y_sum[COMP_W-1:0];
		end
		if (direction_q == DIR_RGB_TO_YCC) begin
			x_in[0] = $signed({1'b0, comp0});
			x_in[1] = $signed({1'b0, comp1});
			x_in[2] = $signed({1'b0, comp2});
		end else begin
			x_in[0] = $signed({1'b0, y_clamp});
			x_in[1] = $signed({~comp1[COMP_W-1], ~comp1[COMP_W-1], comp1[COMP_W-2:0]});
			x_in[2] = $signed({~comp2[COMP_W-1], ~comp2[COMP_W-1], comp2[COMP_W-2:0]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= start;
			ctl_s1.last  <= frame_end;
			ctl_s1.swap  <= swap_q & (direction_q == DIR_YCC_TO_RGB);
		end
	end

	always_ff @(posedge clk) begin
		dir_s1 <= direction_q;
		for (int j = 0; j < 3; j++) begin
			x_s1[j] <= x_in[j];
		end
	end

	ycc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s1 (ctl_s1),
		.dir_s1 (dir_s1),
		.x_s1   (x_s1),
		.ctl_s3 (ctl_s3),
		.acc_s3 (acc_s3)
	);

	ycc_sat u_sat (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s3     (ctl_s3),
		.acc_s3     (acc_s3),
		.done       (done),
		.last_pixel (last_pixel),
		.out0       (out0),
		.out1       (out1),
		.out2       (out2)
	);

endmodule

>>> tb/ycc_convert_check.sv
`timescale 1ns / 100ps
// Checker for the YCbCr/RGB color converter: follows config writes, predicts each pixel
// in Q16 fixed point and compares results in order. Depends on ycc_pkg.
module ycc_convert_check
	import ycc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [COMP_W-1:0]     comp0,
	input  logic [COMP_W-1:0]     comp1,
	input  logic [COMP_W-1:0]     comp2,
	input  logic                  frame_end,
	input  logic                  done,
	input  logic [COMP_W-1:0]     out0,
	input  logic [COMP_W-1:0]     out1,
	input  logic [COMP_W-1:0]     out2,
	input  logic                  last_pixel,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    backlog
);

	typedef struct packed {
		logic [COMP_W-1:0] ch0;
		logic [COMP_W-1:0] ch1;
		logic [COMP_W-1:0] ch2;
		logic              last;
	} pixel_t;

	localparam longint Q_ONE   = 65536;
	localparam longint MID     = 128;
	localparam longint K_CR_R  = 91881;
	localparam longint K_CB_G  = 22554;
	localparam longint K_CR_G  = 46820;
	localparam longint K_CB_B  = 116130;
	localparam longint K_R_Y   = 19595;
	localparam longint K_G_Y   = 38470;
	localparam longint K_B_Y   = 7471;
	localparam longint K_R_CB  = 11056;
	localparam longint K_G_CB  = 21712;
	localparam longint K_HALF  = 32768;
	localparam longint K_G_CR  = 27440;
	localparam longint K_B_CR  = 5328;

	logic                         dir_r;
	logic signed [CFG_DATA_W-1:0] ofs_r;
	logic                         swap_r;
	pixel_t                       expected_pixels[$];
	pixel_t                       got;
	pixel_t                       want;

	// floor a Q16 sum and clamp it to one byte
	function automatic logic [COMP_W-1:0] q16_to_byte(input longint acc);
		if (acc < 0)
			return '0;
		if ((acc >>> 16) > 255)
			return 8'd255;
		return acc[23:16];
	endfunction

	function automatic pixel_t convert_pixel(input logic [COMP_W-1:0] c0, c1, c2,
		input logic fe);
		longint y;
		longint cb;
		longint cr;
		logic [COMP_W-1:0] r;
		logic [COMP_W-1:0] g;
		logic [COMP_W-1:0] b;
		pixel_t p;
		if (dir_r == DIR_YCC_TO_RGB) begin
			y = longint'(c0) + longint'(ofs_r);
			if (y < 0)
				y = 0;
			if (y > 255)
				y = 255;
			cb = longint'(c1) - MID;
			cr = longint'(c2) - MID;
			r = q16_to_byte(y * Q_ONE + K_CR_R * cr);
			g = q16_to_byte(y * Q_ONE - K_CB_G * cb - K_CR_G * cr);
			b = q16_to_byte(y * Q_ONE + K_CB_B * cb);
			p.ch0 = r;
			p.ch1 = swap_r ? b : g;
			p.ch2 = swap_r ? g : b;
		end else begin
			p.ch0 = q16_to_byte(K_R_Y * longint'(c0) + K_G_Y * longint'(c1)
				+ K_B_Y * longint'(c2));
			p.ch1 = q16_to_byte(MID * Q_ONE - K_R_CB * longint'(c0)
				- K_G_CB * longint'(c1) + K_HALF * longint'(c2));
			p.ch2 = q16_to_byte(MID * Q_ONE + K_HALF * longint'(c0)
				- K_G_CR * longint'(c1) - K_B_CR * longint'(c2));
		end
		p.last = fe;
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_r  <= DIR_YCC_TO_RGB;
			ofs_r  <= '0;
			swap_r <= 1'b0;
			expected_pixels.delete();
			errors  = 0;
			backlog = 0;
		end else begin
			if (done) begin
				got = {out0, out1, out2, last_pixel};
				if (expected_pixels.size() == 0) begin
					errors++;
					$display("%0t: unexpected word %0d %0d %0d last %0b", $time,
						got.ch0, got.ch1, got.ch2, got.last);
				end else begin
					want = expected_pixels.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: mismatch, expected %0d %0d %0d last %0b, got %0d %0d %0d last %0b",
							$time, want.ch0, want.ch1, want.ch2, want.last,
							got.ch0, got.ch1, got.ch2, got.last);
					end
				end
			end
			if (start && !busy)
				expected_pixels.push_back(convert_pixel(comp0, comp1, comp2, frame_end));
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_DIRECTION: dir_r  <= cfg_data[0];
					REG_LUMA_OFS:  ofs_r  <= cfg_data;
					REG_SWAP_GB:   swap_r <= cfg_data[0];
					default: ;
				endcase
			end
			backlog = expected_pixels.size();
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the color converter testbench: clock, reset, config writes and pixel stimulus.
// Depends on ycc_pkg, ycbcr_rgb_color_convert and ycc_convert_check.
module tb_top
	import ycc_pkg::*;
();

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int PHASES    = 9;
	localparam int PHASE_LEN = 72;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [COMP_W-1:0]     comp0;
	logic [COMP_W-1:0]     comp1;
	logic [COMP_W-1:0]     comp2;
	logic                  frame_end;
	logic                  done;
	logic [COMP_W-1:0]     out0;
	logic [COMP_W-1:0]     out1;
	logic [COMP_W-1:0]     out2;
	logic                  last_pixel;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  word_taken;
	int                    errors;
	int                    backlog;

	ycbcr_rgb_color_convert dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.comp0(comp0), .comp1(comp1), .comp2(comp2), .frame_end(frame_end),
		.done(done), .out0(out0), .out1(out1), .out2(out2), .last_pixel(last_pixel),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ycc_convert_check chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.comp0(comp0), .comp1(comp1), .comp2(comp2), .frame_end(frame_end),
		.done(done), .out0(out0), .out1(out1), .out2(out2), .last_pixel(last_pixel),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .backlog(backlog)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		word_taken <= start && !busy;
	end

	initial begin
		#200000;
		$display("[ycbcr_rgb_color_convert] ERROR");
		$finish;
	end

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_pixel(input logic [COMP_W-1:0] c0, c1, c2, input logic fe);
		start     <= 1'b1;
		comp0     <= c0;
		comp1     <= c1;
		comp2     <= c2;
		frame_end <= fe;
		@(negedge clk);
		while (!word_taken)
			@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (backlog != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	task automatic set_mode(input logic dir, input logic [CFG_DATA_W-1:0] ofs,
		input logic swap, input logic stray);
		drain();
		write_reg(REG_DIRECTION, {8'($urandom), dir});
		write_reg(REG_LUMA_OFS, ofs);
		write_reg(REG_SWAP_GB, {8'($urandom), swap});
		if (stray)
			write_reg(REG_UNUSED, 9'h1FF);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [COMP_W-1:0] pick_comp();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd128;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	logic [COMP_W-1:0] corner [6][3] = '{
		'{8'd0,   8'd0,   8'd0},
		'{8'd255, 8'd255, 8'd255},
		'{8'd0,   8'd255, 8'd0},
		'{8'd255, 8'd0,   8'd255},
		'{8'd128, 8'd128, 8'd128},
		'{8'd0,   8'd0,   8'd255}
	};

	initial begin
		int idle_pct;
		logic [CFG_DATA_W-1:0] ofs;
		start     = 1'b0;
		comp0     = '0;
		comp1     = '0;
		comp2     = '0;
		frame_end = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corners under reset config, max and min offsets, and RGB-to-YCbCr with swap set
		for (int d = 0; d < 4; d++) begin
			case (d)
				1: set_mode(DIR_YCC_TO_RGB, 9'd255, 1'b1, 1'b0);
				2: set_mode(DIR_YCC_TO_RGB, 9'h100, 1'b0, 1'b1);
				3: set_mode(DIR_RGB_TO_YCC, 9'h180, 1'b1, 1'b0);
				default: ;
			endcase
			for (int k = 0; k < 6; k++)
				send_pixel(corner[k][0], corner[k][1], corner[k][2], k[0]);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			idle_pct = (ph < 3) ? 8 : (ph < 6) ? 53 : 0;
			case ($urandom_range(0, 4))
				0: ofs = 9'h100;
				1: ofs = 9'h180;
				2: ofs = 9'd128;
				3: ofs = 9'd255;
				default: ofs = 9'($urandom);
			endcase
			set_mode(ph[0] ? DIR_RGB_TO_YCC : DIR_YCC_TO_RGB, ofs, 1'($urandom),
				$urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_LEN; n++) begin
				send_pixel(pick_comp(), pick_comp(), pick_comp(), $urandom_range(0, 15) == 0);
				while ($urandom_range(0, 99) < idle_pct) begin
					start <= 1'b0;
					@(negedge clk);
				end
			end
		end

		drain();
		if (errors == 0)
			$display("[ycbcr_rgb_color_convert] OK");
		else
			$display("[ycbcr_rgb_color_convert] ERROR");
		$finish;
	end

endmodule
